### rtl/spf_pkg.sv
// shared types, constants and byte tables of the spi packet command framer
`default_nettype none
package spf_pkg;

    localparam logic [7:0] SPI_IDLE    = 8'h4A;
    localparam logic [7:0] SPI_ESC     = 8'h4D;
    localparam logic [7:0] PK_SOP      = 8'h7A;
    localparam logic [7:0] PK_EOP      = 8'h7B;
    localparam logic [7:0] PK_CHAN     = 8'h7C;
    localparam logic [7:0] PK_ESC      = 8'h7D;
    localparam logic [7:0] TXN_WRITE   = 8'h00;
    localparam logic [7:0] TXN_READ    = 8'h10;
    localparam logic [7:0] TXN_NONE    = 8'h7F;
    localparam logic [7:0] ESC_FLIP    = 8'h20;
    localparam logic [7:0] WORD_SIZE   = 8'h04;
    localparam logic [7:0] BYTE_ZERO   = 8'h00;

    localparam int PAD_W = 5;
    localparam logic [PAD_W-1:0] PAD_LIMIT       = 5'd16;
    localparam logic [PAD_W-1:0] WRITE_PAD_RESET = 5'd11;
    localparam logic [PAD_W-1:0] READ_PAD_RESET  = 5'd13;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_PAD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_PAD  = 1'b1;

    localparam logic [1:0] OPER_WRITE  = 2'd0;
    localparam logic [1:0] OPER_READ   = 2'd1;
    localparam logic [1:0] OPER_PROBE  = 2'd2;
    localparam logic [1:0] OPER_UNUSED = 2'd3;

    localparam int POS_W = 5;
    localparam logic [3:0] HDR_LAST_WRITE = 4'd11;
    localparam logic [3:0] HDR_LAST_READ  = 4'd7;
    localparam logic [POS_W-1:0] PROBE_LAST = 5'd18;

    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_PROBE,
        CMD_ERROR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [31:0]      addr;
        logic [31:0]      data;
        logic [PAD_W-1:0] pad;
    } cq_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cq_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SOP,
        ST_DATA,
        ST_HELD,
        ST_EOP,
        ST_PAD,
        ST_PROBE,
        ST_ERR
    } bk_state_t;

    typedef struct packed {
        bk_state_t state;
    } bk_status_t;

    // transaction header and data word, one byte per position
    function automatic logic [7:0] hdr_byte(input cmd_kind_t kind, input logic [31:0] addr,
                                            input logic [31:0] data, input logic [3:0] pos);
        logic [7:0] b;
        case (pos)
            4'd0:    b = (kind == CMD_WRITE) ? TXN_WRITE : TXN_READ;
            4'd1:    b = BYTE_ZERO;
            4'd2:    b = BYTE_ZERO;
            4'd3:    b = WORD_SIZE;
            4'd4:    b = addr[31:24];
            4'd5:    b = addr[23:16];
            4'd6:    b = addr[15:8];
            4'd7:    b = addr[7:0];
            4'd8:    b = data[7:0];
            4'd9:    b = data[15:8];
            4'd10:   b = data[23:16];
            4'd11:   b = data[31:24];
            default: b = BYTE_ZERO;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] probe_byte(input logic [POS_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = PK_SOP;
            5'd1:    b = TXN_NONE;
            5'd8:    b = PK_EOP;
            5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd9: b = BYTE_ZERO;
            default: b = SPI_IDLE;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

### rtl/spf_front.sv
// command intake: config registers, alignment check and classification
`default_nettype none
module spf_front
    import spf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [PAD_W-1:0]     cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [63:0]          s_tdata,
    input  wire logic [1:0]           s_tuser,
    input  wire cq_status_t           q_status,
    output logic                      q_push,
    output cq_entry_t                 q_entry
);

    logic [PAD_W-1:0] write_pad_reg;
    logic [PAD_W-1:0] read_pad_reg;
    logic [PAD_W-1:0] pad_sel;
    logic [31:0]      addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_pad_reg <= WRITE_PAD_RESET;
            read_pad_reg  <= READ_PAD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_WRITE_PAD: write_pad_reg <= cfg_wdata;
                CFG_READ_PAD:  read_pad_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign addr     = s_tdata[31:0];
    assign s_tready = !q_status.full;
    // unused op code is taken and dropped
    assign q_push   = s_tvalid && s_tready && (s_tuser != OPER_UNUSED);

    always_comb begin
        pad_sel = (s_tuser == OPER_WRITE) ? write_pad_reg : read_pad_reg;
        q_entry.addr = addr;
        q_entry.data = s_tdata[63:32];
        q_entry.pad  = (pad_sel > PAD_LIMIT) ? PAD_LIMIT : pad_sel;
        case (s_tuser)
            OPER_WRITE: q_entry.kind = (addr[1:0] != 2'b00) ? CMD_ERROR : CMD_WRITE;
            OPER_READ:  q_entry.kind = (addr[1:0] != 2'b00) ? CMD_ERROR : CMD_READ;
            OPER_PROBE: q_entry.kind = CMD_PROBE;
            default:    q_entry.kind = CMD_PROBE;
        endcase
    end

endmodule
`default_nettype wire

### rtl/spf_queue.sv
// short command queue between intake and byte sequencer
`default_nettype none
module spf_queue
    import spf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire cq_entry_t push_entry,
    input  wire logic      pop,
    output cq_entry_t      head,
    output cq_status_t     status
);

    cq_entry_t             entries [CQ_DEPTH];
    logic [CQ_PTR_W-1:0]   wr_ptr_reg;
    logic [CQ_PTR_W-1:0]   rd_ptr_reg;
    logic [CQ_CNT_W-1:0]   count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign status.full  = (count_reg == CQ_CNT_W'(CQ_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entries[rd_ptr_reg];

    function automatic logic [CQ_PTR_W-1:0] ptr_inc(input logic [CQ_PTR_W-1:0] p);
        return (p == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/spf_back.sv
// byte sequencer: framing, two escape layers, idle padding, probe pattern, error beat, output register
`default_nettype none
module spf_back
    import spf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cq_entry_t  head,
    input  wire cq_status_t q_status,
    output logic            q_pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic            m_tuser,
    output bk_status_t      status
);

    bk_state_t        state_reg, state_next;
    cmd_kind_t        kind_reg, kind_next;
    logic [31:0]      addr_reg, addr_next;
    logic [31:0]      data_reg, data_next;
    logic [PAD_W-1:0] pad_reg, pad_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       held_reg, held_next;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic             out_mis_reg;

    logic             out_free;
    logic [7:0]       cur;
    logic [3:0]       last_pos;
    logic             at_last;
    logic             pk_esc;
    logic             spi_esc;
    logic             emit;
    logic [7:0]       emit_byte;
    logic             emit_last;
    logic             emit_mis;

    assign out_free = !out_valid_reg || m_tready;
    assign cur      = hdr_byte(kind_reg, addr_reg, data_reg, pos_reg[3:0]);
    assign last_pos = (kind_reg == CMD_WRITE) ? HDR_LAST_WRITE : HDR_LAST_READ;
    assign at_last  = (pos_reg[3:0] == last_pos);
    assign pk_esc   = (cur >= PK_SOP) && (cur <= PK_ESC);
    assign spi_esc  = (cur == SPI_IDLE) || (cur == SPI_ESC);
    assign q_pop    = (state_reg == ST_IDLE) && !q_status.empty;

    // next state
    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        pad_next   = pad_reg;
        pos_next   = pos_reg;
        held_next  = held_reg;
        if (state_reg == ST_IDLE) begin
            if (!q_status.empty) begin
                kind_next = head.kind;
                addr_next = head.addr;
                data_next = head.data;
                pad_next  = head.pad;
                pos_next  = '0;
                case (head.kind)
                    CMD_PROBE: state_next = ST_PROBE;
                    CMD_ERROR: state_next = ST_ERR;
                    default:   state_next = ST_SOP;
                endcase
            end
        end else if (out_free) begin
            case (state_reg)
                ST_SOP: begin
                    pos_next   = '0;
                    state_next = ST_DATA;
                end
                ST_DATA, ST_HELD: begin
                    if (state_reg == ST_DATA && (pk_esc || spi_esc)) begin
                        held_next  = cur ^ ESC_FLIP;
                        state_next = ST_HELD;
                    end else if (at_last) begin
                        state_next = (pad_reg != '0) ? ST_PAD : ST_IDLE;
                    end else begin
                        pos_next   = pos_reg + 1'b1;
                        // eop goes ahead of the final header or data byte
                        state_next = (pos_reg[3:0] + 4'd1 == last_pos) ? ST_EOP : ST_DATA;
                    end
                end
                ST_EOP: state_next = ST_DATA;
                ST_PAD: begin
                    pad_next = pad_reg - 1'b1;
                    if (pad_reg == PAD_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
                ST_PROBE: begin
                    if (pos_reg == PROBE_LAST) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                ST_ERR:  state_next = ST_IDLE;
                default: state_next = ST_IDLE;
            endcase
        end
    end

    // beat contents for the current state
    always_comb begin
        emit      = 1'b1;
        emit_byte = BYTE_ZERO;
        emit_last = 1'b0;
        emit_mis  = 1'b0;
        case (state_reg)
            ST_IDLE: emit = 1'b0;
            ST_SOP:  emit_byte = PK_SOP;
            ST_DATA: begin
                if (pk_esc) begin
                    emit_byte = PK_ESC;
                end else if (spi_esc) begin
                    emit_byte = SPI_ESC;
                end else begin
                    emit_byte = cur;
                    emit_last = at_last && (pad_reg == '0);
                end
            end
            ST_HELD: begin
                emit_byte = held_reg;
                emit_last = at_last && (pad_reg == '0);
            end
            ST_EOP: emit_byte = PK_EOP;
            ST_PAD: begin
                emit_byte = SPI_IDLE;
                emit_last = (pad_reg == PAD_W'(1));
            end
            ST_PROBE: begin
                emit_byte = probe_byte(pos_reg);
                emit_last = (pos_reg == PROBE_LAST);
            end
            ST_ERR: begin
                emit_last = 1'b1;
                emit_mis  = 1'b1;
            end
            default: emit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            pad_reg       <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            pad_reg   <= pad_next;
            held_reg  <= held_next;
            if (out_free) begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        addr_reg <= addr_next;
        data_reg <= data_next;
        if (out_free) begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
            out_mis_reg  <= emit_mis;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_byte_reg;
    assign m_tlast      = out_last_reg;
    assign m_tuser      = out_mis_reg;
    assign status.state = state_reg;

endmodule
`default_nettype wire

### rtl/spi_packet_command_framer.sv
// top level of the spi packet command framer
`default_nettype none
// Turns word write, word read and probe commands into the byte stream for a
// packet bridge behind an SPI link. A write or read becomes an sop, an 8-byte
// header (plus the data word, little-endian, for writes) with eop ahead of
// the final byte, packet escaping of 0x7A..0x7D and SPI escaping of 0x4A and
// 0x4D, followed by write_idle_pad or read_idle_pad idle bytes (capped at 16).
// A probe sends its fixed 19-byte pattern; a misaligned address sends one beat
// with misaligned set and no bytes; op code 3 is dropped. The sequencer puts
// out one byte per cycle while m_tready is high, and passes through its idle
// state between commands to pick the next one up from a two-entry queue.
// The queue lets up to two further commands be taken while one is being sent.
module spi_packet_command_framer
    import spf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [PAD_W-1:0]     cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [63:0]          s_tdata,  // address, data word
    input  wire logic [1:0]           s_tuser,  // operation
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,  // spi_byte
    output logic                      m_tlast,
    output logic                      m_tuser   // misaligned
);

    cq_status_t q_status;
    cq_entry_t  q_entry;
    cq_entry_t  q_head;
    logic       q_push;
    logic       q_pop;
    bk_status_t bk_status;

    spf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    spf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    spf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .q_status (q_status),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .status   (bk_status)
    );

`ifndef SYNTHESIS
    // an error beat is a lone zero byte closing its run
    a_error_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == BYTE_ZERO))
        else $error("misaligned beat without last or with nonzero byte");

    // a waiting command is picked up at once by an idle sequencer
    a_pickup: assert property (@(posedge aclk) disable iff (!aresetn)
        (bk_status.state == ST_IDLE && !q_status.empty) |=> (bk_status.state != ST_IDLE))
        else $error("sequencer stayed idle with a queued command");

    // idle padding ends the run on an idle byte
    a_pad_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (bk_status.state == ST_PAD && m_tvalid && m_tready && m_tlast) |->
        (m_tdata == SPI_IDLE))
        else $error("padding run closed on a non-idle byte");
`endif

endmodule
`default_nettype wire

### tb/tb.sv
// testbench for the spi packet command framer: scoreboard class, stream drivers and top module
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import spf_pkg::*;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       last;
        logic       misaligned;
    } spi_beat_t;

    class spi_scoreboard;
        logic [PAD_W-1:0] write_pad;
        logic [PAD_W-1:0] read_pad;
        int               errors;
        spi_beat_t        beats_due[$];
        spi_beat_t        frame[$];

        function new();
            write_pad = WRITE_PAD_RESET;
            read_pad  = READ_PAD_RESET;
            errors    = 0;
        endfunction

        function void push_raw(logic [7:0] b);
            frame.push_back('{b, 1'b0, 1'b0});
        endfunction

        // link layer: idle and escape bytes go out escaped
        function void push_spi(logic [7:0] b);
            if (b == SPI_IDLE || b == SPI_ESC) begin
                push_raw(SPI_ESC);
                push_raw(b ^ ESC_FLIP);
            end else begin
                push_raw(b);
            end
        endfunction

        // packet layer: sop, eop, channel and escape codes go out escaped
        function void push_packet(logic [7:0] b);
            if (b >= PK_SOP && b <= PK_ESC) begin
                push_spi(PK_ESC);
                push_spi(b ^ ESC_FLIP);
            end else begin
                push_spi(b);
            end
        endfunction

        // work out the beats one accepted command sends
        function void frame_command(logic [1:0] op, logic [31:0] addr, logic [31:0] data);
            logic [7:0]       hdr[12];
            int               len;
            logic [PAD_W-1:0] pad;
            frame = {};
            case (op)
                OPER_PROBE: begin
                    push_raw(PK_SOP);
                    push_raw(TXN_NONE);
                    repeat (6) push_raw(BYTE_ZERO);
                    push_raw(PK_EOP);
                    push_raw(BYTE_ZERO);
                    repeat (9) push_raw(SPI_IDLE);
                end
                OPER_WRITE, OPER_READ: begin
                    if (addr[1:0] != 2'b00) begin
                        frame.push_back('{BYTE_ZERO, 1'b1, 1'b1});
                    end else begin
                        hdr[0]  = (op == OPER_WRITE) ? TXN_WRITE : TXN_READ;
                        hdr[1]  = BYTE_ZERO;
                        hdr[2]  = BYTE_ZERO;
                        hdr[3]  = WORD_SIZE;
                        hdr[4]  = addr[31:24];
                        hdr[5]  = addr[23:16];
                        hdr[6]  = addr[15:8];
                        hdr[7]  = addr[7:0];
                        hdr[8]  = data[7:0];
                        hdr[9]  = data[15:8];
                        hdr[10] = data[23:16];
                        hdr[11] = data[31:24];
                        len = (op == OPER_WRITE) ? 12 : 8;
                        for (int i = 0; i < len; i++) begin
                            if (i == 0) push_spi(PK_SOP);
                            if (i == len - 1) push_spi(PK_EOP);
                            push_packet(hdr[4'(i)]);
                        end
                        pad = (op == OPER_WRITE) ? write_pad : read_pad;
                        if (pad > PAD_LIMIT) pad = PAD_LIMIT;
                        repeat (pad) push_raw(SPI_IDLE);
                    end
                end
                default: ;
            endcase
            if (frame.size() > 0) frame[frame.size() - 1].last = 1'b1;
            foreach (frame[i]) beats_due.push_back(frame[i]);
        endfunction

        function void check_beat(logic [7:0] b, logic last, logic misaligned);
            spi_beat_t want;
            if (beats_due.size() == 0) begin
                $display("%0t: unexpected beat: byte %h last %b misaligned %b",
                         $time, b, last, misaligned);
                errors++;
                return;
            end
            want = beats_due.pop_front();
            if ({b, last, misaligned} !== want) begin
                $display("%0t: mismatch: expected %h last %b mis %b, got %h last %b mis %b",
                         $time, want.spi_byte, want.last, want.misaligned, b, last, misaligned);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = CFG_WRITE_PAD;
    logic [PAD_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata   = '0;  // address, data word
    logic [1:0]           s_tuser   = OPER_WRITE;  // operation
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;  // spi_byte
    logic                 m_tlast;
    logic                 m_tuser;  // misaligned

    int            send_idle = 33;
    int            recv_idle = 56;
    spi_scoreboard board;

    spi_packet_command_framer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: check each accepted beat, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_beat(m_tdata, m_tlast, m_tuser);
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_cmd(input logic [1:0] op, input logic [31:0] addr,
                            input logic [31:0] data);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {data, addr};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.frame_command(op, addr, data);
    endtask

    // let every expected beat arrive, then give dropped commands time to clear
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.beats_due.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic set_pads(input logic [PAD_W-1:0] wpad, input logic [PAD_W-1:0] rpad);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_WRITE_PAD;
        cfg_wdata <= wpad;
        @(posedge aclk);
        cfg_addr  <= CFG_READ_PAD;
        cfg_wdata <= rpad;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.write_pad = wpad;
        board.read_pad  = rpad;
    endtask

    // half the picks come from the codes that the framing layers escape
    function automatic logic [7:0] pick_byte();
        logic [7:0] codes[6] = '{SPI_IDLE, SPI_ESC, PK_SOP, PK_EOP, PK_CHAN, PK_ESC};
        logic [7:0] b;
        if ($urandom_range(1) == 1) b = 8'($urandom_range(255));
        else b = codes[3'($urandom_range(5))];
        return b;
    endfunction

    task automatic run_random(input int count);
        int          done;
        int          r;
        logic [1:0]  op;
        logic [31:0] addr;
        logic [31:0] data;
        done = 0;
        while (done < count) begin
            r    = $urandom_range(99);
            addr = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
            data = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
            if (r < 40) op = OPER_WRITE;
            else if (r < 70) op = OPER_READ;
            else if (r < 85) op = OPER_PROBE;
            else if (r < 95) op = ($urandom_range(1) == 1) ? OPER_WRITE : OPER_READ;
            else op = OPER_UNUSED;
            // misaligned only in the 85..94 slice
            if (r < 85 || r >= 95) addr[1:0] = 2'b00;
            else if (addr[1:0] == 2'b00) addr[1:0] = 2'($urandom_range(3, 1));
            send_cmd(op, addr, data);
            if (op != OPER_UNUSED) done++;
        end
    endtask

    initial begin
        board = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_cmd(OPER_WRITE, 32'h0000_0000, 32'h0000_0000);
        send_cmd(OPER_WRITE, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
        send_cmd(OPER_READ, 32'h0000_0000, 32'hFFFF_FFFF);
        send_cmd(OPER_READ, 32'hFFFF_FFFC, 32'h0000_0000);
        send_cmd(OPER_PROBE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(OPER_PROBE, 32'h0000_0000, 32'h0000_0000);
        send_cmd(OPER_WRITE, 32'h0000_0001, 32'h1234_5678);
        send_cmd(OPER_READ, 32'h0000_0002, 32'h0000_0000);
        send_cmd(OPER_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(OPER_READ, 32'h8000_0003, 32'h0000_0000);
        send_cmd(OPER_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(OPER_WRITE, 32'h7A7B_7C7C, 32'h7D4D_4A7A);
        send_cmd(OPER_READ, 32'h4A4D_7D00, 32'h0000_0000);
        send_cmd(OPER_WRITE, 32'h4D4A_7B4C, 32'h7C7B_4A4D);
        send_cmd(OPER_READ, 32'h7D7A_4A7C, 32'hFFFF_FFFF);
        send_cmd(OPER_UNUSED, 32'h0000_0000, 32'h0000_0000);
        send_cmd(OPER_WRITE, 32'h1234_5678, 32'h9ABC_DEF0);
        send_cmd(OPER_READ, 32'h4A4A_4A48, 32'h0000_0000);
        send_cmd(OPER_PROBE, $urandom, $urandom);
        drain();

        set_pads(5'd0, 5'd0);
        run_random(40);
        drain();

        send_idle = 56;
        recv_idle = 33;
        set_pads(5'd31, 5'd16);
        run_random(40);
        drain();

        send_idle = 0;
        recv_idle = 0;
        set_pads(5'd16, 5'd31);
        run_random(40);
        drain();

        set_pads(5'($urandom_range(31)), 5'($urandom_range(31)));
        run_random(40);
        drain();

        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
